/* src/h264ps_pkg.sv */
// ----------------------------------------------------------------------------
// h264ps_pkg
// Shared types and constants for the Annex B parameter-set locator
// ----------------------------------------------------------------------------
package h264ps_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int RES_BITS        = 24;

    localparam logic [31:0] START_CODE = 32'h0000_0001;
    localparam logic [4:0]  NAL_MASK   = 5'h1F;
    localparam logic [4:0]  NAL_SEI    = 5'h06;
    localparam logic [4:0]  NAL_IDR    = 5'h05;
    localparam logic [4:0]  NAL_PPS    = 5'h08;

    typedef enum logic [1:0]
    {
        KIND_SEI = 2'd1,
        KIND_IDR = 2'd2
    } kind_t;

    typedef struct packed
    {
        logic       last_byte;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed
    {
        logic [RES_BITS-1:0] pps_length;
        logic [RES_BITS-1:0] pps_start;
        logic [RES_BITS-1:0] sps_length;
        logic                pps_found;
        logic [RES_BITS-1:0] idr_payload_off;
    } result_t;

endpackage

/* src/h264ps_in_stage.sv */
// ----------------------------------------------------------------------------
// h264ps_in_stage
// Input register holding one stream byte until the scanner takes it
// ----------------------------------------------------------------------------
module h264ps_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  h264ps_pkg::item_t s_item,
    input  logic              take,
    output logic              item_vld,
    output h264ps_pkg::item_t item
);
    import h264ps_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_ready  = !vld_reg || take;
    assign vld_next = (s_valid && s_ready) || (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

/* src/h264ps_scanner.sv */
// ----------------------------------------------------------------------------
// h264ps_scanner
// Start code search, SEI/IDR/PPS tracking and end-of-buffer result
// ----------------------------------------------------------------------------
module h264ps_scanner #(
    parameter int OFFSET_BITS = h264ps_pkg::OFFSET_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_vld,
    input  h264ps_pkg::item_t   item,
    input  logic                out_free,
    output logic                take,
    output logic                res_load,
    output h264ps_pkg::result_t res
);
    import h264ps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_ZERO = {OFFSET_BITS{1'b0}};
    localparam logic [OFFSET_BITS-1:0] OFF_FOUR = OFFSET_BITS'(4);

    logic [31:0]            window_reg,     window_next;
    logic [OFFSET_BITS-1:0] count_reg,      count_next;
    logic                   pend_vld_reg,   pend_vld_next;
    kind_t                  pend_kind_reg,  pend_kind_next;
    logic [OFFSET_BITS-1:0] pend_pos_reg,   pend_pos_next;
    logic [OFFSET_BITS-1:0] conf_end_reg,   conf_end_next;
    logic [OFFSET_BITS-1:0] idr_off_reg,    idr_off_next;
    logic                   stopped_reg,    stopped_next;
    logic [OFFSET_BITS-1:0] pps_pos_reg,    pps_pos_next;
    logic                   pps_seen_reg,   pps_seen_next;

    logic [OFFSET_BITS-1:0] conf_end_cur;
    logic [OFFSET_BITS-1:0] idr_off_cur;
    logic                   stopped_cur;
    logic [OFFSET_BITS-1:0] pps_pos_cur;
    logic                   pps_seen_cur;
    logic                   detect;
    logic [4:0]             type_bits;
    logic [OFFSET_BITS-1:0] pos_now;

    logic [OFFSET_BITS:0]   p_ext;
    logic                   found;
    logic [OFFSET_BITS-1:0] sps_len;
    logic [OFFSET_BITS:0]   pps_st;
    logic [OFFSET_BITS-1:0] pps_len;
    logic [OFFSET_BITS+23:0] idr_wide;
    logic [OFFSET_BITS+23:0] sps_wide;
    logic [OFFSET_BITS+23:0] st_wide;
    logic [OFFSET_BITS+23:0] len_wide;

    assign take      = item_vld && (!item.last_byte || out_free);
    assign res_load  = take && item.last_byte;
    assign type_bits = item.data_byte[4:0] & NAL_MASK;
    assign pos_now   = count_reg - OFF_FOUR;

    // confirm the pending sei/idr, then look for a type byte
    always_comb
    begin
        conf_end_cur = conf_end_reg;
        idr_off_cur  = idr_off_reg;
        stopped_cur  = stopped_reg;
        if (pend_vld_reg && !stopped_reg)
        begin
            case (pend_kind_reg)
                KIND_SEI:
                begin
                    conf_end_cur = pend_pos_reg;
                end
                KIND_IDR:
                begin
                    if (conf_end_reg == OFF_ZERO)
                    begin
                        conf_end_cur = pend_pos_reg;
                    end
                    idr_off_cur = pend_pos_reg + OFF_FOUR;
                    stopped_cur = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        detect = !stopped_cur && (count_reg >= OFF_FOUR) && (count_reg != OFF_MAX)
                 && (window_reg == START_CODE);

        pend_vld_next  = 1'b0;
        pend_kind_next = KIND_SEI;
        pend_pos_next  = pos_now;
        pps_pos_cur    = pps_pos_reg;
        pps_seen_cur   = pps_seen_reg;
        if (detect)
        begin
            if (type_bits == NAL_SEI)
            begin
                pend_vld_next  = 1'b1;
                pend_kind_next = KIND_SEI;
            end
            else if (type_bits == NAL_IDR)
            begin
                pend_vld_next  = 1'b1;
                pend_kind_next = KIND_IDR;
            end
            else if (type_bits == NAL_PPS && !pps_seen_reg)
            begin
                pps_pos_cur  = pos_now;
                pps_seen_cur = 1'b1;
            end
        end
    end

    // end-of-buffer result
    always_comb
    begin
        p_ext    = {1'b0, pps_pos_cur};
        found    = pps_seen_cur && ((p_ext + (OFFSET_BITS+1)'(5)) < {1'b0, conf_end_cur});
        sps_len  = (pps_pos_cur >= OFF_FOUR) ? (pps_pos_cur - OFF_FOUR) : OFF_ZERO;
        pps_st   = p_ext + (OFFSET_BITS+1)'(4);
        pps_len  = conf_end_cur - pps_pos_cur - OFF_FOUR;
        idr_wide = {24'd0, idr_off_cur};
        sps_wide = {24'd0, sps_len};
        st_wide  = {23'd0, pps_st};
        len_wide = {24'd0, pps_len};

        res.idr_payload_off = idr_wide[RES_BITS-1:0];
        res.pps_found       = found;
        res.sps_length      = found ? sps_wide[RES_BITS-1:0] : '0;
        res.pps_start       = found ? st_wide[RES_BITS-1:0]  : '0;
        res.pps_length      = found ? len_wide[RES_BITS-1:0] : '0;
    end

    always_comb
    begin
        window_next   = {window_reg[23:0], item.data_byte};
        count_next    = (count_reg == OFF_MAX) ? count_reg : (count_reg + OFFSET_BITS'(1));
        conf_end_next = conf_end_cur;
        idr_off_next  = idr_off_cur;
        stopped_next  = stopped_cur;
        pps_pos_next  = pps_pos_cur;
        pps_seen_next = pps_seen_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            count_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            pend_kind_reg <= KIND_SEI;
            pend_pos_reg  <= '0;
            conf_end_reg  <= '0;
            idr_off_reg   <= '0;
            stopped_reg   <= 1'b0;
            pps_pos_reg   <= '0;
            pps_seen_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                window_reg    <= '0;
                count_reg     <= '0;
                pend_vld_reg  <= 1'b0;
                pend_kind_reg <= KIND_SEI;
                pend_pos_reg  <= '0;
                conf_end_reg  <= '0;
                idr_off_reg   <= '0;
                stopped_reg   <= 1'b0;
                pps_pos_reg   <= '0;
                pps_seen_reg  <= 1'b0;
            end
            else
            begin
                window_reg    <= window_next;
                count_reg     <= count_next;
                pend_vld_reg  <= pend_vld_next;
                pend_kind_reg <= pend_kind_next;
                pend_pos_reg  <= pend_pos_next;
                conf_end_reg  <= conf_end_next;
                idr_off_reg   <= idr_off_next;
                stopped_reg   <= stopped_next;
                pps_pos_reg   <= pps_pos_next;
                pps_seen_reg  <= pps_seen_next;
            end
        end
    end

endmodule

/* src/h264ps_out_stage.sv */
// ----------------------------------------------------------------------------
// h264ps_out_stage
// Result register towards the master-side stream
// ----------------------------------------------------------------------------
module h264ps_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_load,
    input  h264ps_pkg::result_t res,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [95:0]         m_data,
    output logic                m_user
);
    import h264ps_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign out_free = !vld_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (res_load)
        begin
            vld_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = vld_reg;
    assign m_data  = {res_reg.pps_length, res_reg.pps_start,
                      res_reg.sps_length, res_reg.idr_payload_off};
    assign m_user  = res_reg.pps_found;

endmodule

/* src/h264_annexb_param_set_locator.sv */
// Takes an H.264 Annex B stream one byte per request and, on the byte marked
// with tlast, returns one result with the IDR payload offset and the SPS/PPS
// layout of the configuration region; all tracking then restarts for the next
// buffer. One byte is accepted every cycle unless a last byte is waiting; the
// result is registered through the input register and then the result register. A last
// byte waits in the input register only while an earlier result is still held.
// ----------------------------------------------------------------------------
// h264_annexb_param_set_locator
// Top level: input register, scanner and result register
// ----------------------------------------------------------------------------
module h264_annexb_param_set_locator #(
    parameter int OFFSET_BITS = h264ps_pkg::OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // idr payload offset, sps_length, pps_start, pps_length
    output logic        m_axis_tuser    // pps_found
);
    import h264ps_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_vld;
    logic    take;
    logic    res_load;
    logic    out_free;
    result_t res;

    assign s_item.data_byte = s_axis_tdata;
    assign s_item.last_byte = s_axis_tlast;

    h264ps_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_item   (s_item),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    h264ps_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .out_free (out_free),
        .take     (take),
        .res_load (res_load),
        .res      (res)
    );

    h264ps_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .m_user   (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(take && item.last_byte))
        else $error("result raised without a last byte");

    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !item_vld |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_body_flows : assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld && !item.last_byte) |-> (take && s_axis_tready))
        else $error("non-last byte stalled");
`endif

endmodule

/* tb/tb_h264_annexb_param_set_locator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_annexb_param_set_locator
// Byte-stream check of the Annex B parameter-set locator: buffers of NAL units
// (ordered SPS/PPS/SEI/IDR layouts, random type mixes and plain noise) are fed
// one byte per request, a scoreboard tracks start codes alongside the block and
// every end-of-buffer result is compared field by field, under several mixes
// of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_h264_annexb_param_set_locator;

    import h264ps_pkg::*;

    localparam int OFFSET_BITS = OFFSET_BITS_DEF;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam int PHASE_ITEMS = 300;

    // hand-built buffers: lone last byte, sei at zero then idr, pps at start
    // with its region closed by an sei and a trailing idr type byte as last
    localparam item_t DIRECTED [29] = '{
        9'h1FF,
        9'h000, 9'h000, 9'h000, 9'h001, 9'h006, 9'h000, 9'h000, 9'h000, 9'h001,
        9'h025, 9'h100,
        9'h000, 9'h000, 9'h000, 9'h001, 9'h068, 9'h080, 9'h000, 9'h000, 9'h000,
        9'h001, 9'h006, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h001, 9'h145
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // idr payload offset, sps_length, pps_start, pps_length
    logic        m_axis_tuser;           // pps_found

    item_t       byte_q [$];
    logic [7:0]  build_q [$];
    result_t     layout_q [$];
    item_t       next_item;
    result_t     want, got, fresh;
    logic        in_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_queued = 0;
    int          fail_count = 0;

    // scoreboard copy of the scanner state
    logic [31:0]            win = '0;
    logic [OFFSET_BITS-1:0] count = '0;
    logic                   pend_valid = 1'b0;
    kind_t                  pend_kind = KIND_SEI;
    logic [OFFSET_BITS-1:0] pend_pos = '0;
    logic [OFFSET_BITS-1:0] cfg_end = '0;
    logic [OFFSET_BITS-1:0] idr_off = '0;
    logic                   stopped = 1'b0;
    logic [OFFSET_BITS-1:0] pps_pos = '0;
    logic                   pps_hit = 1'b0;

    h264_annexb_param_set_locator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
        logic [OFFSET_BITS-1:0] n;
        logic [OFFSET_BITS-1:0] p;
        logic [4:0]             t;
        logic [63:0]            pos64;
        logic [63:0]            end64;
        bit                     found;
        n = count;
        r = '0;
        // the byte after a type byte confirms a pending sei or idr
        if (pend_valid && !stopped)
        begin
            if (pend_kind == KIND_SEI)
                cfg_end = pend_pos;
            else if (pend_kind == KIND_IDR)
            begin
                if (cfg_end == '0)
                    cfg_end = pend_pos;
                idr_off = pend_pos + OFFSET_BITS'(4);
                stopped = 1'b1;
            end
        end
        pend_valid = 1'b0;
        if (!stopped && n >= OFFSET_BITS'(4) && n < COUNT_MAX && win == START_CODE)
        begin
            t = b[4:0] & NAL_MASK;
            p = n - OFFSET_BITS'(4);
            if (t == NAL_SEI)
            begin
                pend_valid = 1'b1;
                pend_kind = KIND_SEI;
                pend_pos = p;
            end
            else if (t == NAL_IDR)
            begin
                pend_valid = 1'b1;
                pend_kind = KIND_IDR;
                pend_pos = p;
            end
            else if (t == NAL_PPS && !pps_hit)
            begin
                pps_pos = p;
                pps_hit = 1'b1;
            end
        end
        win = {win[23:0], b};
        if (count < COUNT_MAX)
            count = count + 1'b1;
        if (!last)
            return 1'b0;
        pos64 = 64'(pps_pos);
        end64 = 64'(cfg_end);
        found = pps_hit && (pos64 + 64'd5 < end64);
        r.idr_payload_off = RES_BITS'(idr_off);
        r.pps_found = found;
        r.sps_length = (found && pos64 >= 64'd4) ? RES_BITS'(pos64 - 64'd4) : '0;
        r.pps_start = found ? RES_BITS'(pos64 + 64'd4) : '0;
        r.pps_length = found ? RES_BITS'(end64 - pos64 - 64'd4) : '0;
        // new buffer starts from scratch
        win = '0;
        count = '0;
        pend_valid = 1'b0;
        cfg_end = '0;
        idr_off = '0;
        stopped = 1'b0;
        pps_pos = '0;
        pps_hit = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [4:0] rand_type();
        case ($urandom_range(0, 5))
            0: return NAL_SEI;
            1: return NAL_IDR;
            2: return NAL_PPS;
            3: return NAL_SPS;
            4: return NAL_SLICE;
            default: return 5'($urandom);
        endcase
    endfunction

    function automatic int rand_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(16, 150);
        return $urandom_range(0, 5);
    endfunction

    task automatic add_nal(input logic [4:0] t, input int plen);
        // mostly four-byte start codes, now and then a short three-byte one
        if ($urandom_range(0, 11) != 0)
            build_q.push_back(8'h00);
        build_q.push_back(8'h00);
        build_q.push_back(8'h00);
        build_q.push_back(8'h01);
        build_q.push_back({3'($urandom), t});
        repeat (plen)
            build_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    endtask

    task automatic close_buffer();
        foreach (build_q[i])
            byte_q.push_back(item_t'{last_byte: (i == build_q.size() - 1),
                                     data_byte: build_q[i]});
        items_queued += build_q.size();
        build_q.delete();
    endtask

    task automatic check_field(input string field, input logic [RES_BITS-1:0] want_v,
                               input logic [RES_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0d, got %0d", field, want_v, got_v);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_item.data_byte;
                    s_axis_tlast <= next_item.last_byte;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.idr_payload_off = m_axis_tdata[23:0];
                got.sps_length = m_axis_tdata[47:24];
                got.pps_start = m_axis_tdata[71:48];
                got.pps_length = m_axis_tdata[95:72];
                got.pps_found = m_axis_tuser;
                if (layout_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: tdata %h tuser %b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = layout_q.pop_front();
                    check_field("idr_payload_off", want.idr_payload_off,
                                got.idr_payload_off);
                    check_field("pps_found", RES_BITS'(want.pps_found), RES_BITS'(got.pps_found));
                    check_field("sps_length", want.sps_length, got.sps_length);
                    check_field("pps_start", want.pps_start, got.pps_start);
                    check_field("pps_length", want.pps_length, got.pps_length);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                if (scan_byte(s_axis_tdata, s_axis_tlast, fresh))
                    layout_q.push_back(fresh);
        end
    end

    initial
    begin
        int shape;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            byte_q.push_back(DIRECTED[i]);
        items_queued = $size(DIRECTED);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            while (items_queued < $size(DIRECTED) + PHASE_ITEMS * (ph + 1))
            begin
                shape = $urandom_range(0, 9);
                if (shape < 2)
                begin
                    // noise rich in zeros and ones, start codes by chance
                    repeat ($urandom_range(1, 24))
                        build_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                                     : 8'($urandom_range(0, 1)));
                end
                else if (shape < 7)
                begin
                    // usual stream head
                    add_nal(NAL_SPS, rand_len());
                    add_nal(NAL_PPS, rand_len());
                    repeat ($urandom_range(0, 2))
                        add_nal(NAL_SEI, rand_len());
                    add_nal(NAL_IDR, rand_len());
                    repeat ($urandom_range(0, 2))
                        add_nal(rand_type(), rand_len());
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        add_nal(rand_type(), rand_len());
                end
                close_buffer();
            end
            // sender holds off until every result of this phase is back
            while (byte_q.size() != 0 || s_axis_tvalid)
                @(posedge clk);
            while (layout_q.size() != 0)
                @(posedge clk);
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && layout_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
